// File: hw/rtl/fixed_point_fully_connected_core_defines.svh
// ----------------------------------------------------------------------------
// fixed_point_fully_connected_core_defines
// Assertion macros shared by the fully connected core files.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_FULLY_CONNECTED_CORE_DEFINES_SVH
`define FIXED_POINT_FULLY_CONNECTED_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock outside reset
`define FPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define FPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPFC_ASSERT(lbl, prop, msg)
`define FPFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/fpfc_pkg.sv
// ----------------------------------------------------------------------------
// fpfc_pkg
// Widths, codes and shared types of the fixed-point fully connected core.
// ----------------------------------------------------------------------------
package fpfc_pkg;

  // store depths
  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_OUTPUTS = 64;

  // field widths
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 16;
  localparam int VAL_W      = 16;
  localparam int OUT_ROW_W  = 6;
  localparam int FRAC_W     = 4;
  localparam int IN_LEN_W   = 11;
  localparam int OUT_LEN_W  = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 32;

  // address widths
  localparam int WADDR_W = IDX_W;
  localparam int WDEPTH  = 2 ** WADDR_W;
  localparam int AIDX_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int ROW_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  // saturation bounds in accumulator width
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (VAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_ACT    = 2'd2,
    FUNC_NOP    = 2'd3
  } fpfc_func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAC_BITS     = 2'd0,
    CFG_INPUT_LENGTH  = 2'd1,
    CFG_OUTPUT_LENGTH = 2'd2
  } fpfc_cfg_idx_t;

  // control that travels with each product through the mac pipeline
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             lastcol;
    logic             lastrow;
    logic [ROW_W-1:0] row;
  } fpfc_tag_t;

  // one finished row
  typedef struct packed {
    logic signed [VAL_W-1:0] out_value;
    logic [OUT_ROW_W-1:0]    out_row;
    logic                    last;
    logic                    clamped;
  } fpfc_res_t;

endpackage

// File: hw/rtl/fpfc_if.sv
// ----------------------------------------------------------------------------
// fpfc_if
// Valid/ready channels for requests into and rows out of the core.
// ----------------------------------------------------------------------------

// request channel: at most one store write per request
interface fpfc_in_if;
  import fpfc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

// result channel: one finished row per transfer
interface fpfc_out_if;
  import fpfc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [OUT_ROW_W-1:0]    out_row;
  logic                    last;
  logic                    clamped;

  modport source (output valid, out_value, out_row, last, clamped, input ready);
  modport sink   (input valid, out_value, out_row, last, clamped, output ready);
endinterface

// File: hw/rtl/fpfc_mac.sv
// ----------------------------------------------------------------------------
// fpfc_mac
// Multiply, accumulate, shift and clamp pipeline with the output register.
// ----------------------------------------------------------------------------
`include "fixed_point_fully_connected_core_defines.svh"

module fpfc_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fpfc_pkg::fpfc_tag_t               tag_in,
  input  logic [fpfc_pkg::VAL_W-1:0]        wgt,
  input  logic [fpfc_pkg::VAL_W-1:0]        act,
  input  logic [fpfc_pkg::VAL_W-1:0]        bias,
  input  logic [fpfc_pkg::FRAC_W-1:0]       frac,
  input  logic                              out_ready,
  output logic                              adv,
  output logic                              out_vld,
  output fpfc_pkg::fpfc_res_t               res
);
  import fpfc_pkg::*;

  fpfc_tag_t               tag2_r;
  fpfc_tag_t               fin_r;
  fpfc_tag_t               fin_nxt;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] prod_nxt;
  logic [VAL_W-1:0]        bias2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] shifted;
  logic signed [VAL_W-1:0] sat_val;
  logic                    sat_flag;
  logic                    out_vld_r;
  fpfc_res_t               res_r;

  // whole pipeline moves unless a finished row is held at the output
  assign adv = !out_vld_r || out_ready;

  // product stage
  assign prod_nxt = ACC_W'($signed(act)) * ACC_W'($signed(wgt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (adv) begin
      tag2_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      bias2_r <= bias;
    end
  end

  // accumulate stage, bias scaled in on the first column
  assign base    = ACC_W'($signed(bias2_r)) << frac;
  assign acc_nxt = (tag2_r.first ? base : acc_r) + prod_r;

  always_comb begin
    fin_nxt     = tag2_r;
    fin_nxt.vld = tag2_r.vld && tag2_r.lastcol;
  end

  always_ff @(posedge clk) begin
    if (adv && tag2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= '0;
    end else if (adv) begin
      fin_r <= fin_nxt;
    end
  end

  // scale back and saturate
  assign shifted = acc_r >>> frac;

  always_comb begin
    priority if (shifted > SAT_HI) begin
      sat_val  = VAL_W'(SAT_HI);
      sat_flag = 1'b1;
    end else if (shifted < SAT_LO) begin
      sat_val  = VAL_W'(SAT_LO);
      sat_flag = 1'b1;
    end else begin
      sat_val  = VAL_W'(shifted);
      sat_flag = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fin_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_r.vld) begin
      res_r.out_value <= sat_val;
      res_r.out_row   <= OUT_ROW_W'(fin_r.row);
      res_r.last      <= fin_r.lastrow;
      res_r.clamped   <= sat_flag;
    end
  end

  assign out_vld = out_vld_r;
  assign res     = res_r;

  // checks
  `FPFC_ASSERT_NEXT(a_col_order, tag2_r.vld && !tag2_r.lastcol && adv, !(tag2_r.vld && tag2_r.first), "first column follows an unfinished row")
  `FPFC_ASSERT_NEXT(a_fin_hold, fin_r.vld && !adv, fin_r.vld, "finished row lost during output stall")
  `FPFC_ASSERT_NEXT(a_last_row, tag2_r.vld && tag2_r.lastcol && tag2_r.lastrow && adv, fin_r.vld && fin_r.lastrow, "last row not passed to the output stage")

endmodule

// File: hw/rtl/fixed_point_fully_connected_core.sv
// ----------------------------------------------------------------------------
// fixed_point_fully_connected_core
// Fully connected layer in 16-bit fixed point. The write of activation
// input_length-1 starts the layer: a single multiply-accumulate unit walks
// the weight memory one product per cycle, the request channel is not
// ready until the walk ends, and the last row passes through the product,
// accumulate and output registers after its final weight read. Result
// stalls stop the walk. Unwritten store entries read as undefined data.
// ----------------------------------------------------------------------------
`include "fixed_point_fully_connected_core_defines.svh"

module fixed_point_fully_connected_core (
  input  logic                               clk,
  input  logic                               rst_n,
  fpfc_in_if.sink                            in_ch,
  fpfc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [fpfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fpfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fpfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } fpfc_state_t;

  logic [FRAC_W-1:0]    frac_r;
  logic [IN_LEN_W-1:0]  in_len_r;
  logic [OUT_LEN_W-1:0] out_len_r;
  logic [AIDX_W-1:0]    nin_m1;
  logic [ROW_W-1:0]     nout_m1;

  fpfc_state_t          state_r, state_nxt;
  logic [AIDX_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [WADDR_W-1:0]   waddr_r, waddr_nxt;
  fpfc_tag_t            tag1_r, tag1_nxt;

  logic                 in_acc;
  fpfc_func_t           func;
  logic                 w_we, b_we, a_we, trig;
  logic                 adv, issue;

  logic [VAL_W-1:0]     wmem [WDEPTH];
  logic [VAL_W-1:0]     amem [MAX_INPUTS];
  logic [VAL_W-1:0]     bmem [MAX_OUTPUTS];
  logic [VAL_W-1:0]     w_rd_r, a_rd_r, b_rd_r;

  logic                 out_vld;
  fpfc_res_t            res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r    <= '0;
      in_len_r  <= IN_LEN_W'(1);
      out_len_r <= OUT_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (fpfc_cfg_idx_t'(cfg_index))
        CFG_FRAC_BITS:     frac_r    <= cfg_wdata[FRAC_W-1:0];
        CFG_INPUT_LENGTH:  in_len_r  <= cfg_wdata[IN_LEN_W-1:0];
        CFG_OUTPUT_LENGTH: out_len_r <= cfg_wdata[OUT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths saturated to the store sizes, minus one; a zero length counts as one
  always_comb begin
    priority if (in_len_r == '0) begin
      nin_m1 = '0;
    end else if (32'(in_len_r) > MAX_INPUTS) begin
      nin_m1 = AIDX_W'(MAX_INPUTS - 1);
    end else begin
      nin_m1 = AIDX_W'(in_len_r - IN_LEN_W'(1));
    end
  end

  always_comb begin
    priority if (out_len_r == '0) begin
      nout_m1 = '0;
    end else if (32'(out_len_r) > MAX_OUTPUTS) begin
      nout_m1 = ROW_W'(MAX_OUTPUTS - 1);
    end else begin
      nout_m1 = ROW_W'(out_len_r - OUT_LEN_W'(1));
    end
  end

  // request decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign func        = fpfc_func_t'(in_ch.func);
  assign w_we        = in_acc && (func == FUNC_WEIGHT);
  assign b_we        = in_acc && (func == FUNC_BIAS) && (32'(in_ch.index) < MAX_OUTPUTS);
  assign a_we        = in_acc && (func == FUNC_ACT) && (32'(in_ch.index) < MAX_INPUTS);
  assign trig        = a_we && (in_ch.index == IDX_W'(nin_m1));

  assign issue = adv && (state_r == ST_RUN);

  // weight memory
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[in_ch.index] <= in_ch.value;
    end
    if (issue) begin
      w_rd_r <= wmem[waddr_r];
    end
  end

  // activation memory
  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[in_ch.index[AIDX_W-1:0]] <= in_ch.value;
    end
    if (issue) begin
      a_rd_r <= amem[col_r];
    end
  end

  // bias memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[in_ch.index[ROW_W-1:0]] <= in_ch.value;
    end
    if (issue) begin
      b_rd_r <= bmem[row_r];
    end
  end

  // row and column walk
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    waddr_nxt = waddr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (trig) begin
          state_nxt = ST_RUN;
          col_nxt   = '0;
          row_nxt   = '0;
          waddr_nxt = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          waddr_nxt = waddr_r + WADDR_W'(1);
          if (col_r == nin_m1) begin
            col_nxt = '0;
            if (row_r == nout_m1) begin
              state_nxt = ST_IDLE;
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            col_nxt = col_r + AIDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      waddr_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      waddr_r <= waddr_nxt;
    end
  end

  // control aligned with the memory read data
  always_comb begin
    tag1_nxt.vld     = (state_r == ST_RUN);
    tag1_nxt.first   = (col_r == '0);
    tag1_nxt.lastcol = (col_r == nin_m1);
    tag1_nxt.lastrow = (row_r == nout_m1);
    tag1_nxt.row     = row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (adv) begin
      tag1_r <= tag1_nxt;
    end
  end

  // arithmetic pipeline and output register
  fpfc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag1_r),
    .wgt       (w_rd_r),
    .act       (a_rd_r),
    .bias      (b_rd_r),
    .frac      (frac_r),
    .out_ready (out_ch.ready),
    .adv       (adv),
    .out_vld   (out_vld),
    .res       (res)
  );

  assign out_ch.valid     = out_vld;
  assign out_ch.out_value = res.out_value;
  assign out_ch.out_row   = res.out_row;
  assign out_ch.last      = res.last;
  assign out_ch.clamped   = res.clamped;

  // checks
  `FPFC_ASSERT(a_state_onehot, $onehot(state_r), "state register not one-hot")
  `FPFC_ASSERT_NEXT(a_trig_start, trig, state_r == ST_RUN && col_r == '0 && row_r == '0 && waddr_r == '0, "layer walk did not start from row zero")
  `FPFC_ASSERT(a_walk_range, state_r == ST_RUN |-> col_r <= nin_m1 && row_r <= nout_m1, "walk counters beyond the lengths in use")

endmodule
